### rtl/layered_led_color_effect_engine_assert.svh
// Assertion macros shared by the LED effect engine RTL.
`ifndef LAYERED_LED_COLOR_EFFECT_ENGINE_ASSERT_SVH
`define LAYERED_LED_COLOR_EFFECT_ENGINE_ASSERT_SVH

// same-cycle implication
`define LLCE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// invariant
`define LLCE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

### rtl/llce_pkg.sv
// Types, codes and constants of the layered LED effect engine.
package llce_pkg;

   localparam int LED_COUNT_DEF   = 16;
   localparam int LAYER_COUNT_DEF = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [2:0] MODE_BLACK = 3'd0;
   localparam logic [2:0] MODE_FIXED = 3'd1;
   localparam logic [2:0] MODE_HUE   = 3'd2;
   localparam logic [2:0] MODE_RAMP  = 3'd3;
   localparam logic [2:0] MODE_PULSE = 3'd4;

   localparam logic [9:0] MAXV      = 10'd1023;
   localparam logic [9:0] HUE_MAX   = 10'd239;
   localparam logic [3:0] RAMP_LAST = 4'd12;

   // hue arithmetic runs on 11-bit signed values
   localparam logic signed [10:0] HUE_SPAN    = 11'sd240;
   localparam logic signed [10:0] HUE_SECTOR  = 11'sd40;
   localparam logic [5:0]         SECTOR_W6   = 6'd40;
   // 2^21 / 40 rounded up, exact for x*1023 with x in 0..40
   localparam logic [32:0]        RECIP_SECTOR = 33'd52429;

   typedef struct packed {
      logic [2:0]        mode;
      logic [9:0]        a;
      logic [9:0]        b;
      logic [9:0]        c;
      logic [9:0]        d;
      logic signed [8:0] step;
   } slot_type;

   typedef struct packed {
      logic [9:0] r;
      logic [9:0] g;
      logic [9:0] b;
   } rgb_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_HUE_WRAP,
      ST_HUE_SECTOR,
      ST_HUE_UP,
      ST_HUE_DOWN,
      ST_HUE_SET,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                      we;
      logic                      rd_en;
   } mem_ctl_type;

endpackage

### rtl/layered_led_color_effect_engine.sv
// Layered LED color effect engine: slot table, effect sequencer and result port.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  req     | in        | req_valid / req_stall | func, led/layer index, mode, params
//  rsp     | out       | rsp_valid / rsp_stall | out_led, red, green, blue, last
//  csr     | in        | csr_wr_en             | csr_wr_data (enable)
//
// A slot write transaction is taken in the idle state, and so is a disabled tick.
// An enabled tick runs every LED and layer slot through one sequencer: each slot is read
// from the table and evaluated, a hue rotate slot then goes through wrap, sector steps, two
// multiplier passes and write-back, and each LED ends in the emit state.
// After reset a clearing pass zeroes all 2^(LED_W+LAY_W) = 32 table entries; csr writes land.
// req_stall is high whenever the sequencer is not idle; rsp_stall holds it in the emit state.
`include "layered_led_color_effect_engine_assert.svh"

module layered_led_color_effect_engine
   import llce_pkg::*;
#(
   parameter int LED_COUNT   = LED_COUNT_DEF,
   parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [3:0]        req_led_index,
   input  logic              req_layer_index,
   input  logic [2:0]        req_effect_mode,
   input  logic [9:0]        req_param_a,
   input  logic [9:0]        req_param_b,
   input  logic [9:0]        req_param_c,
   input  logic [9:0]        req_param_d,
   input  logic signed [8:0] req_hue_step,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_out_led,
   output logic [9:0]        rsp_red,
   output logic [9:0]        rsp_green,
   output logic [9:0]        rsp_blue,
   output logic              rsp_last,
   // configuration
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int LAY_W  = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
   localparam int ADDR_W = LED_W + LAY_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               enable_ff, enable_in;
   rgb_type            run_ff, run_in;
   logic [LED_W-1:0]   led_ff, led_in;
   logic [LAY_W-1:0]   lay_ff, lay_in;
   logic signed [10:0] acc_ff, acc_in;     // hue sum, then sector remainder
   logic [7:0]         hue_ff, hue_in;
   logic [2:0]         sec_ff, sec_in;
   logic [9:0]         up_ff, up_in;
   logic [9:0]         dn_ff, dn_in;
   slot_type           slot_ff;            // registered table read

   slot_type           slot_mem [DEPTH];

   // ------------------------------------------------------------------
   // request decode and write normalization
   // ------------------------------------------------------------------
   logic              req_take;
   logic              req_in_range;
   logic [7:0]        req_led_ext;
   logic [3:0]        req_lay_ext;
   logic [ADDR_W-1:0] req_addr;
   slot_type          wr_slot;

   assign req_take     = req_valid && !req_stall;
   assign req_led_ext  = {4'b0, req_led_index};
   assign req_lay_ext  = {3'b0, req_layer_index};
   assign req_in_range = (req_led_ext < 8'(LED_COUNT)) && (req_lay_ext < 4'(LAYER_COUNT));
   assign req_addr     = {req_lay_ext[LAY_W-1:0], req_led_ext[LED_W-1:0]};

   always_comb begin
      wr_slot.mode = req_effect_mode;
      wr_slot.a    = req_param_a;
      wr_slot.b    = req_param_b;
      wr_slot.c    = req_param_c;
      wr_slot.d    = req_param_d;
      wr_slot.step = req_hue_step;
      case (req_effect_mode)
         MODE_HUE: begin
            if (req_param_a > HUE_MAX) wr_slot.a = HUE_MAX;
         end
         MODE_RAMP: begin
            wr_slot.b = {6'b0, req_param_b[3:0]};
         end
         MODE_PULSE: begin
            wr_slot.b = {2'b0, req_param_b[7:0]};
            wr_slot.c = {2'b0, req_param_c[7:0]};
            wr_slot.d = {2'b0, req_param_d[7:0]};
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // slot evaluation (everything but hue rotate is evaluated combinationally)
   // ------------------------------------------------------------------
   logic              last_layer;
   logic              last_led;
   logic              skip_slot;
   logic              is_hue;
   logic [ADDR_W-1:0] slot_addr;
   logic              eval_set;
   rgb_type           eval_rgb;
   slot_type          eval_slot;
   logic              eval_wb;
   logic [9:0]        lv;
   logic [3:0]        ph;
   logic [4:0]        ph_next;
   logic [9:0]        pb;

   assign last_layer = (lay_ff == LAY_W'(LAYER_COUNT - 1));
   assign last_led   = (led_ff == LED_W'(LED_COUNT - 1));
   assign skip_slot  = (lay_ff != '0) && (slot_ff.mode == MODE_BLACK);
   assign is_hue     = !skip_slot && (slot_ff.mode == MODE_HUE);
   assign slot_addr  = {lay_ff, led_ff};

   always_comb begin
      eval_set  = 1'b0;
      eval_rgb  = '0;
      eval_slot = slot_ff;
      eval_wb   = 1'b0;
      lv        = slot_ff.a;
      ph        = slot_ff.b[3:0];
      ph_next   = '0;
      pb        = slot_ff.b;
      case (slot_ff.mode)
         MODE_FIXED: begin
            eval_set = 1'b1;
            eval_rgb = '{r: slot_ff.a, g: slot_ff.b, b: slot_ff.c};
         end
         MODE_HUE: begin
            // handled by the hue sub-sequence
         end
         MODE_RAMP: begin
            eval_set = 1'b1;
            case (ph)
               4'd0:    eval_rgb = '{r: 10'd0,      g: lv,         b: 10'd0};
               4'd1:    eval_rgb = '{r: 10'd0,      g: MAXV,       b: 10'd0};
               4'd2:    eval_rgb = '{r: lv,         g: MAXV,       b: 10'd0};
               4'd3:    eval_rgb = '{r: MAXV,       g: MAXV,       b: 10'd0};
               4'd4:    eval_rgb = '{r: MAXV,       g: MAXV - lv,  b: 10'd0};
               4'd5:    eval_rgb = '{r: MAXV,       g: 10'd0,      b: 10'd0};
               4'd6:    eval_rgb = '{r: MAXV,       g: 10'd0,      b: lv};
               4'd7:    eval_rgb = '{r: MAXV,       g: 10'd0,      b: MAXV};
               4'd8:    eval_rgb = '{r: MAXV - lv,  g: 10'd0,      b: MAXV};
               4'd9:    eval_rgb = '{r: 10'd0,      g: 10'd0,      b: MAXV};
               4'd10:   eval_rgb = '{r: 10'd0,      g: lv,         b: MAXV};
               4'd11:   eval_rgb = '{r: 10'd0,      g: MAXV,       b: MAXV};
               4'd12:   eval_rgb = '{r: 10'd0,      g: MAXV,       b: MAXV - lv};
               default: eval_rgb = '0;
            endcase
            eval_wb = 1'b1;
            if (lv == MAXV) begin
               ph_next = {1'b0, ph} + 5'd1;
               if (ph_next > {1'b0, RAMP_LAST}) ph_next = 5'd1;
               eval_slot.a = 10'd0;
               eval_slot.b = {5'b0, ph_next};
            end else begin
               eval_slot.a = lv + 10'd1;
               eval_slot.b = {6'b0, ph};
            end
         end
         MODE_PULSE: begin
            eval_wb = 1'b1;
            if (slot_ff.a == 10'd0) begin
               if (pb > 10'd1) pb = 10'd0;
               if (pb == 10'd0) begin
                  eval_set = 1'b1;
                  eval_rgb = '{r: MAXV, g: 10'd0, b: 10'd0};
               end
            end
            if (slot_ff.c[7:0] == 8'd0) begin
               eval_slot.c = {2'b0, slot_ff.d[7:0] - 8'd1};
               eval_slot.b = {2'b0, pb[7:0] + 8'd1};
            end else begin
               eval_slot.c = {2'b0, slot_ff.c[7:0] - 8'd1};
               eval_slot.b = pb;
            end
         end
         default: begin
            eval_set = 1'b1;
            eval_rgb = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // shared hue adder and fraction multiplier
   // ------------------------------------------------------------------
   logic signed [10:0] alu_a, alu_b, alu_sum;
   logic [5:0]         mul_x;
   logic [15:0]        mul_n;
   logic [32:0]        mul_prod;
   logic [9:0]         mul_q;
   rgb_type            hue_rgb;

   always_comb begin
      alu_a = acc_ff;
      alu_b = '0;
      case (state_ff)
         ST_EVAL: begin
            alu_a = $signed({1'b0, slot_ff.a});
            alu_b = {{2{slot_ff.step[8]}}, slot_ff.step};
         end
         ST_HUE_WRAP: begin
            if (acc_ff < 11'sd0)          alu_b = HUE_SPAN;
            else if (acc_ff >= HUE_SPAN)  alu_b = -HUE_SPAN;
            else                          alu_b = '0;
         end
         ST_HUE_SECTOR: begin
            alu_b = -HUE_SECTOR;
         end
         default: begin
         end
      endcase
   end

   assign alu_sum = alu_a + alu_b;

   // x * 1023 / 40 by reciprocal multiplication
   assign mul_x    = (state_ff == ST_HUE_DOWN) ? (SECTOR_W6 - acc_ff[5:0]) : acc_ff[5:0];
   assign mul_n    = {mul_x, 10'b0} - {10'b0, mul_x};
   assign mul_prod = {17'b0, mul_n} * RECIP_SECTOR;
   assign mul_q    = mul_prod[30:21];

   always_comb begin
      case (sec_ff)
         3'd0:    hue_rgb = '{r: MAXV,  g: up_ff, b: 10'd0};
         3'd1:    hue_rgb = '{r: dn_ff, g: MAXV,  b: 10'd0};
         3'd2:    hue_rgb = '{r: 10'd0, g: MAXV,  b: up_ff};
         3'd3:    hue_rgb = '{r: 10'd0, g: dn_ff, b: MAXV};
         3'd4:    hue_rgb = '{r: up_ff, g: 10'd0, b: MAXV};
         default: hue_rgb = '{r: MAXV,  g: 10'd0, b: dn_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_func == FUNC_TICK && enable_ff) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (is_hue)          state_in = ST_HUE_WRAP;
            else if (last_layer) state_in = ST_EMIT;
            else                 state_in = ST_READ;
         end
         ST_HUE_WRAP: begin
            state_in = ST_HUE_SECTOR;
         end
         ST_HUE_SECTOR: begin
            if (acc_ff < HUE_SECTOR) state_in = ST_HUE_UP;
         end
         ST_HUE_UP: begin
            state_in = ST_HUE_DOWN;
         end
         ST_HUE_DOWN: begin
            state_in = ST_HUE_SET;
         end
         ST_HUE_SET: begin
            state_in = last_layer ? ST_EMIT : ST_READ;
         end
         ST_EMIT: begin
            if (!rsp_stall) state_in = last_led ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: outputs and table port
   // ------------------------------------------------------------------
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_wa;
   slot_type          mem_wd;

   always_comb begin
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      mem_ctl.we    = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_wa        = slot_addr;
      mem_wd        = eval_slot;
      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.we = 1'b1;
            mem_wa     = clr_ff;
            mem_wd     = '0;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            mem_ctl.we = req_valid && (req_func == FUNC_WRITE) && req_in_range;
            mem_wa     = req_addr;
            mem_wd     = wr_slot;
         end
         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
         end
         ST_EVAL: begin
            mem_ctl.we = !skip_slot && eval_wb;
         end
         ST_HUE_SET: begin
            mem_ctl.we = 1'b1;
            mem_wd     = slot_ff;
            mem_wd.a   = {2'b0, hue_ff};
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      clr_in    = clr_ff;
      enable_in = csr_wr_en ? csr_wr_data : enable_ff;
      run_in    = run_ff;
      led_in    = led_ff;
      lay_in    = lay_ff;
      acc_in    = acc_ff;
      hue_in    = hue_ff;
      sec_in    = sec_ff;
      up_in     = up_ff;
      dn_in     = dn_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_take && req_func == FUNC_TICK) begin
               led_in = '0;
               lay_in = '0;
            end
         end
         ST_EVAL: begin
            if (!skip_slot && eval_set) run_in = eval_rgb;
            if (is_hue) acc_in = alu_sum;
            else if (!last_layer) lay_in = lay_ff + LAY_W'(1);
         end
         ST_HUE_WRAP: begin
            acc_in = alu_sum;
            hue_in = alu_sum[7:0];
            sec_in = '0;
         end
         ST_HUE_SECTOR: begin
            if (acc_ff >= HUE_SECTOR) begin
               acc_in = alu_sum;
               sec_in = sec_ff + 3'd1;
            end
         end
         ST_HUE_UP: begin
            up_in = mul_q;
         end
         ST_HUE_DOWN: begin
            dn_in = mul_q;
         end
         ST_HUE_SET: begin
            run_in = hue_rgb;
            if (!last_layer) lay_in = lay_ff + LAY_W'(1);
         end
         ST_EMIT: begin
            if (!rsp_stall && !last_led) begin
               led_in = led_ff + LED_W'(1);
               lay_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         enable_ff <= 1'b1;
         run_ff    <= '0;
         led_ff    <= '0;
         lay_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         enable_ff <= enable_in;
         run_ff    <= run_in;
         led_ff    <= led_in;
         lay_ff    <= lay_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      hue_ff <= hue_in;
      sec_ff <= sec_in;
      up_ff  <= up_in;
      dn_ff  <= dn_in;
   end

   // slot table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_ctl.we) slot_mem[mem_wa] <= mem_wd;
      if (mem_ctl.rd_en) slot_ff <= slot_mem[slot_addr];
   end

   // ------------------------------------------------------------------
   // response port
   // ------------------------------------------------------------------
   logic [7:0] led_ext;

   assign led_ext     = 8'(led_ff);
   assign rsp_out_led = led_ext[3:0];
   assign rsp_red     = run_ff.r;
   assign rsp_green   = run_ff.g;
   assign rsp_blue    = run_ff.b;
   assign rsp_last    = last_led;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `LLCE_ASSERT_IMPLIES(a_no_rsp_while_ready, clock, reset,
                        !req_stall, !rsp_valid, "response pending while request side ready")
   `LLCE_ASSERT_NEXT(a_idle_after_last, clock, reset,
                     rsp_valid && !rsp_stall && rsp_last, !req_stall,
                     "sequencer not idle after final LED transaction")
   `LLCE_ASSERT_ALWAYS(a_sector_range, clock, reset,
                       sec_ff <= 3'd5 || state_ff != ST_HUE_SET, "hue sector out of range")
   `LLCE_ASSERT_IMPLIES(a_hue_wrapped, clock, reset, state_ff == ST_HUE_SECTOR,
                        !acc_ff[10] && hue_ff < 8'd240, "hue not wrapped into range")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the layered LED color effect engine: slot writes, frame ticks, enable.
module tb_top
   import llce_pkg::*;
();

   localparam int LEDS       = LED_COUNT_DEF;
   localparam int LAYERS     = LAYER_COUNT_DEF;
   localparam int QUIET_WAIT = 20;     // idle cycles after the last color before a csr write
   localparam int STALL_MAX  = 3000;   // cycles with no transaction on either channel
   localparam int SHOW_MAX   = 40;     // mismatch lines printed before going quiet

   // one request transaction as presented on the req_ channel
   typedef struct {
      logic              func;
      logic [3:0]        led;
      logic              layer;
      logic [2:0]        mode;
      logic [9:0]        a;
      logic [9:0]        b;
      logic [9:0]        c;
      logic [9:0]        d;
      logic signed [8:0] step;
   } led_req_type;

   // one color transaction on the rsp_ channel
   typedef struct {
      logic [3:0] led;
      logic [9:0] r;
      logic [9:0] g;
      logic [9:0] b;
      logic       last_led;
   } led_color_type;

   // effect slot as the engine keeps it
   typedef struct {
      logic [2:0]        mode;
      logic [9:0]        a;
      logic [9:0]        b;
      logic [9:0]        c;
      logic [9:0]        d;
      logic signed [8:0] step;
   } effect_slot_type;

   // DUT inputs start at known values
   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_func        = FUNC_WRITE;
   logic [3:0]        req_led_index   = '0;
   logic              req_layer_index = 1'b0;
   logic [2:0]        req_effect_mode = MODE_BLACK;
   logic [9:0]        req_param_a     = '0;
   logic [9:0]        req_param_b     = '0;
   logic [9:0]        req_param_c     = '0;
   logic [9:0]        req_param_d     = '0;
   logic signed [8:0] req_hue_step    = '0;
   logic              rsp_stall       = 1'b0;
   logic              csr_wr_en       = 1'b0;
   logic              csr_wr_data     = 1'b0;

   logic              req_stall;
   logic              rsp_valid;
   logic [3:0]        rsp_out_led;
   logic [9:0]        rsp_red;
   logic [9:0]        rsp_green;
   logic [9:0]        rsp_blue;
   logic              rsp_last;

   layered_led_color_effect_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_led_index   (req_led_index),
      .req_layer_index (req_layer_index),
      .req_effect_mode (req_effect_mode),
      .req_param_a     (req_param_a),
      .req_param_b     (req_param_b),
      .req_param_c     (req_param_c),
      .req_param_d     (req_param_d),
      .req_hue_step    (req_hue_step),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_led     (rsp_out_led),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the engine: slot table, running color and enable bit.
   // ------------------------------------------------------------------
   effect_slot_type slots [LAYERS][LEDS];
   logic [9:0]      run_r, run_g, run_b;
   logic            engine_on;

   led_req_type     req_queue [$];     // transactions waiting for the driver
   led_color_type   colors_due [$];    // colors the engine still owes, oldest first

   int errors        = 0;
   int items_queued  = 0;
   int items_taken   = 0;
   int ticks_lit     = 0;
   int colors_seen   = 0;
   int enable_writes = 0;
   int idle_cycles   = 0;

   function automatic void paint(int r, int g, int b);
      run_r = 10'(r);
      run_g = 10'(g);
      run_b = 10'(b);
   endfunction

   // full saturation/value HSV, six sectors of 40 hue steps
   function automatic void paint_hue(int hue);
      int sec, ph, up, dn;
      sec = hue / 40;
      ph  = hue % 40;
      up  = ph * 1023 / 40;
      dn  = (40 - ph) * 1023 / 40;
      case (sec)
         0: paint(1023, up, 0);
         1: paint(dn, 1023, 0);
         2: paint(0, 1023, up);
         3: paint(0, dn, 1023);
         4: paint(up, 0, 1023);
         default: paint(1023, 0, dn);
      endcase
   endfunction

   // evaluate one slot: updates the running color and the slot's animation
   function automatic void run_slot(int lay, int led);
      effect_slot_type s;
      int h, lv, ph;
      s = slots[lay][led];
      case (s.mode)
         MODE_FIXED: paint(s.a, s.b, s.c);
         MODE_HUE: begin
            h   = int'(s.a) + int'(s.step);
            h   = (h + 480) % 240;
            s.a = 10'(h);
            paint_hue(h);
         end
         MODE_RAMP: begin
            lv = s.a;
            ph = s.b[3:0];
            case (ph)
               0:  paint(0, lv, 0);
               1:  paint(0, 1023, 0);
               2:  paint(lv, 1023, 0);
               3:  paint(1023, 1023, 0);
               4:  paint(1023, 1023 - lv, 0);
               5:  paint(1023, 0, 0);
               6:  paint(1023, 0, lv);
               7:  paint(1023, 0, 1023);
               8:  paint(1023 - lv, 0, 1023);
               9:  paint(0, 0, 1023);
               10: paint(0, lv, 1023);
               11: paint(0, 1023, 1023);
               12: paint(0, 1023, 1023 - lv);
               default: paint(0, 0, 0);
            endcase
            // level wraps into the next phase; past the last phase back to 1
            if (lv == 1023) begin
               lv = 0;
               ph = ph + 1;
               if (ph > 12) ph = 1;
            end else begin
               lv = lv + 1;
            end
            s.a = 10'(lv);
            s.b = 10'(ph);
         end
         MODE_PULSE: begin
            // submode 0: phase 0 flashes red, phase 1 lets the color through
            if (s.a == 0) begin
               if (s.b > 1) s.b = '0;
               if (s.b == 0) paint(1023, 0, 0);
            end
            if (s.c[7:0] == 8'd0) begin
               s.c = {2'b00, 8'(s.d - 1)};
               s.b = {2'b00, 8'(s.b + 1)};
            end else begin
               s.c = {2'b00, 8'(s.c - 1)};
            end
         end
         default: paint(0, 0, 0);
      endcase
      slots[lay][led] = s;
   endfunction

   // apply one accepted request transaction and queue the colors it yields
   function automatic void predict_transaction(led_req_type t);
      effect_slot_type s;
      led_color_type   col;
      if (t.func == FUNC_WRITE) begin
         s.mode = t.mode;
         s.a    = t.a;
         s.b    = t.b;
         s.c    = t.c;
         s.d    = t.d;
         s.step = t.step;
         if (s.mode == MODE_HUE && s.a > HUE_MAX) s.a = HUE_MAX;
         if (s.mode == MODE_RAMP) s.b = {6'd0, s.b[3:0]};
         if (s.mode == MODE_PULSE) begin
            s.b = {2'b00, s.b[7:0]};
            s.c = {2'b00, s.c[7:0]};
            s.d = {2'b00, s.d[7:0]};
         end
         slots[t.layer][t.led] = s;
         return;
      end
      if (!engine_on) return;
      ticks_lit++;
      for (int led = 0; led < LEDS; led++) begin
         for (int lay = 0; lay < LAYERS; lay++) begin
            if (lay == 0 || slots[lay][led].mode != MODE_BLACK) run_slot(lay, led);
         end
         col.led      = 4'(led);
         col.r        = run_r;
         col.g        = run_g;
         col.b        = run_b;
         col.last_led = (led == LEDS - 1);
         colors_due.push_back(col);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_item(led_req_type t);
      req_queue.push_back(t);
      items_queued++;
   endfunction

   function automatic void queue_write(int led, int lay, logic [2:0] mode, int a, int b,
                                       int c, int d, int step);
      led_req_type t;
      t.func  = FUNC_WRITE;
      t.led   = 4'(led);
      t.layer = 1'(lay);
      t.mode  = mode;
      t.a     = 10'(a);
      t.b     = 10'(b);
      t.c     = 10'(c);
      t.d     = 10'(d);
      t.step  = 9'(step);
      queue_item(t);
   endfunction

   // tick with junk in the ignored fields
   function automatic void queue_tick();
      led_req_type t;
      t.func  = FUNC_TICK;
      t.led   = 4'($urandom);
      t.layer = 1'($urandom);
      t.mode  = 3'($urandom);
      t.a     = 10'($urandom);
      t.b     = 10'($urandom);
      t.c     = 10'($urandom);
      t.d     = 10'($urandom);
      t.step  = 9'($urandom_range(0, 478) - 239);
      queue_item(t);
   endfunction

   // small values for pulse counters so phases actually move within a run
   function automatic int pulse_field();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                         : int'($urandom_range(0, 3));
   endfunction

   // mostly slot writes with effect-specific content, about one tick in four
   function automatic void queue_random();
      int pick, a;
      logic [2:0] mode;
      if ($urandom_range(0, 3) == 0) begin
         queue_tick();
         return;
      end
      pick = $urandom_range(0, 9);
      case (pick)
         0:       mode = MODE_BLACK;
         1, 2:    mode = MODE_FIXED;
         3, 4:    mode = MODE_HUE;
         5, 6:    mode = MODE_RAMP;
         7, 8:    mode = MODE_PULSE;
         default: mode = MODE_PULSE + 3'($urandom_range(1, 3));
      endcase
      case (mode)
         MODE_HUE: begin
            a = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 1023))
                                            : int'($urandom_range(0, 239));
            queue_write($urandom_range(0, 15), $urandom_range(0, 1), mode, a,
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 478) - 239);
         end
         MODE_RAMP: begin
            // often start near the top of the level so the phase rolls over
            a = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1000, 1023))
                                            : int'($urandom_range(0, 1023));
            queue_write($urandom_range(0, 15), $urandom_range(0, 1), mode, a,
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 478) - 239);
         end
         MODE_PULSE: begin
            a = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 1023)) : 0;
            queue_write($urandom_range(0, 15), $urandom_range(0, 1), mode, a,
                        pulse_field(), pulse_field(), pulse_field(),
                        $urandom_range(0, 478) - 239);
         end
         default:
            queue_write($urandom_range(0, 15), $urandom_range(0, 1), mode,
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 478) - 239);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver: presents queued transactions with random gaps.
   // ------------------------------------------------------------------
   led_req_type req_cur;
   int          req_wait  = 0;
   bit          req_burst = 0;
   logic        req_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_transaction(req_cur);
            items_taken++;
         end
         // free to move on when nothing is shown or the shown one was taken
         if (!req_valid || !req_stall) begin
            req_next = 1'b0;
            if (req_wait > 0) begin
               req_wait--;
            end else if (req_queue.size() > 0) begin
               req_cur         = req_queue.pop_front();
               req_func        <= req_cur.func;
               req_led_index   <= req_cur.led;
               req_layer_index <= req_cur.layer;
               req_effect_mode <= req_cur.mode;
               req_param_a     <= req_cur.a;
               req_param_b     <= req_cur.b;
               req_param_c     <= req_cur.c;
               req_param_d     <= req_cur.d;
               req_hue_step    <= req_cur.step;
               req_next = 1'b1;
               // gap before the following transaction; now and then a burst
               if ($urandom_range(0, 11) == 0) req_burst = !req_burst;
               req_wait = req_burst ? 0 : int'($urandom_range(0, 7));
            end
            req_valid <= req_next;
         end
      end
   end

   // ------------------------------------------------------------------
   // Color monitor: random back-pressure, in-order field compare.
   // ------------------------------------------------------------------
   int  rsp_hold  = 0;
   bit  rsp_burst = 0;

   function automatic void check_field(string what, logic [3:0] led, logic [9:0] want,
                                       logic [9:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= SHOW_MAX)
            $display("%0t: LED %0d %s mismatch, expected %0d, got %0d",
                     $time, led, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      led_color_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            colors_seen++;
            if (colors_due.size() == 0) begin
               errors++;
               if (errors <= SHOW_MAX)
                  $display("%0t: unexpected color, expected none, got LED %0d rgb %0d %0d %0d",
                           $time, rsp_out_led, rsp_red, rsp_green, rsp_blue);
            end else begin
               want = colors_due.pop_front();
               check_field("index", want.led, {6'd0, want.led}, {6'd0, rsp_out_led});
               check_field("red", want.led, want.r, rsp_red);
               check_field("green", want.led, want.g, rsp_green);
               check_field("blue", want.led, want.b, rsp_blue);
               check_field("last flag", want.led, {9'd0, want.last_led}, {9'd0, rsp_last});
            end
            if ($urandom_range(0, 11) == 0) rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : int'($urandom_range(0, 7));
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transaction means the engine hung.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
         $display("FAIL layered_led_color_effect_engine");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: phases of stimulus with enable changes in between.
   // ------------------------------------------------------------------

   // wait until every request is taken and every color has come back,
   // then let the engine settle before touching the csr
   task automatic wait_quiet();
      while (items_taken != items_queued || colors_due.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic set_enable(logic on);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      engine_on = on;
      enable_writes++;
   endtask

   initial begin
      for (int lay = 0; lay < LAYERS; lay++)
         for (int led = 0; led < LEDS; led++)
            slots[lay][led] = '{MODE_BLACK, 10'd0, 10'd0, 10'd0, 10'd0, 9'sd0};
      paint(0, 0, 0);
      engine_on = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_enable(1'b1);

      // directed: cleared table first, then one of each effect and edge case
      queue_tick();
      queue_write(0, 0, MODE_FIXED, 1023, 0, 1023, 1023, 0);
      queue_write(15, 0, MODE_FIXED, 0, 1023, 0, 0, 0);
      queue_write(1, 0, MODE_HUE, 1023, 0, 0, 0, 239);         // hue saturates to 239
      queue_write(2, 0, MODE_HUE, 0, 0, 0, 0, -239);           // wraps below zero
      queue_write(3, 0, MODE_RAMP, 1022, 1023, 0, 0, 0);       // phase 15 -> black
      queue_write(4, 0, MODE_RAMP, 1023, 12, 0, 0, 0);         // last phase rolls to 1
      queue_write(5, 0, MODE_PULSE, 0, 1023, 0, 0, 0);         // bad phase reset, step 0
      queue_write(6, 0, MODE_PULSE, 1023, 1, 1, 2, 0);         // nonzero submode
      queue_write(0, 1, MODE_PULSE, 0, 1, 2, 1, 0);            // phase 1 passes color
      queue_write(7, 0, 3'd7, 1023, 1023, 1023, 1023, -1);     // unused mode -> black
      queue_write(8, 0, MODE_FIXED, 512, 256, 128, 0, 0);
      queue_write(8, 1, 3'd5, 0, 0, 0, 0, 0);                  // top layer black wins
      queue_write(9, 1, MODE_HUE, 100, 0, 0, 0, -1);
      queue_write(10, 0, MODE_BLACK, 1023, 1023, 1023, 1023, 239);
      queue_write(11, 1, MODE_RAMP, 0, 0, 0, 0, 0);
      queue_tick();
      queue_tick();
      queue_tick();
      queue_tick();
      wait_quiet();

      // disabled: ticks give nothing, writes still land
      set_enable(1'b0);
      queue_tick();
      queue_write(12, 0, MODE_FIXED, 1, 2, 3, 4, 5);
      queue_tick();
      wait_quiet();
      set_enable(1'b1);
      queue_tick();
      wait_quiet();

      // random part in four chunks, with a disabled stretch in the middle
      for (int chunk = 0; chunk < 4; chunk++) begin
         for (int i = 0; i < 20; i++) queue_random();
         wait_quiet();
         if (chunk == 1) begin
            set_enable(1'b0);
            for (int i = 0; i < 6; i++) queue_random();
            wait_quiet();
            set_enable(1'b1);
         end
      end

      // anything still owed at this point never arrived
      if (colors_due.size() != 0) begin
         errors++;
         $display("%0t: %0d colors expected but never seen", $time, colors_due.size());
      end

      $display("Covered %0d request transactions (%0d lit frames), %0d colors checked,",
               items_taken, ticks_lit, colors_seen);
      $display("%0d enable writes, back-pressure on both channels; %0d mismatches.",
               enable_writes, errors);
      if (errors == 0)
         $display("PASS layered_led_color_effect_engine");
      else
         $display("FAIL layered_led_color_effect_engine");
      $finish;
   end

endmodule
